>>> hdl/assert_macros.svh
// Assertion macros used by the ALU output stage
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define FPA_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define FPA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

>>> hdl/fpa_pkg.sv
// Types, constants and op codes of the fixed-point ALU
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;
    localparam int FRAC_BITS = 8;
    localparam int NUM_W     = 32 + FRAC_BITS;

    // bounds of add/sub and mul results, scaled by 2^F and 2^2F
    localparam logic signed [63:0] ADD_HI =
        64'sd2147483648 - (64'sd1 <<< FRAC_BITS);
    localparam logic signed [63:0] ADD_LO = -64'sd2147483648;
    localparam logic signed [63:0] MUL_HI =
        ((64'sd1 <<< (31 - FRAC_BITS)) - 64'sd1) <<< (2 * FRAC_BITS);
    localparam logic signed [63:0] MUL_LO =
        -((64'sd1 <<< (31 - FRAC_BITS)) <<< (2 * FRAC_BITS));
    // bounds of the divide quotient magnitude
    localparam logic [NUM_W-1:0] DIV_POS_HI =
        NUM_W'(64'd2147483648 - (64'd1 << FRAC_BITS));
    localparam logic [NUM_W-1:0] DIV_NEG_HI = NUM_W'(64'd2147483648);

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_LT    = 4'd4,
        OP_GT    = 4'd5,
        OP_LE    = 4'd6,
        OP_GE    = 4'd7,
        OP_EQ    = 4'd8,
        OP_NE    = 4'd9,
        OP_MIN   = 4'd10,
        OP_MAX   = 4'd11,
        OP_TOINT = 4'd12,
        OP_INC   = 4'd13
    } t_op;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] a_raw;
        logic signed [31:0] b_raw;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_raw;
        logic               compare_true;
        logic               out_of_range;
        logic               div_zero;
    } t_out;

    // everything that rides along the divider chain
    typedef struct packed {
        logic [3:0]         op;
        logic signed [63:0] val;
        logic signed [31:0] pre_res;
        logic               cmp;
        logic               dz;
        logic               neg;
        logic [31:0]        rem;
        logic [31:0]        d;
        logic [NUM_W-1:0]   nq;
    } t_div_st;
endpackage
`default_nettype wire

>>> hdl/fpa_front.sv
// Entry stage: decode, simple ops, multiply and divider setup
`timescale 1ns / 1ps
`default_nettype none
module fpa_front import fpa_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_vld,
    input  wire t_in     i_req,
    output logic         o_rdy,
    output logic         o_vld,
    output t_div_st      o_st,
    input  wire logic    i_rdy
);
    logic    r_vld;
    t_div_st r_st, n_st;
    logic [31:0] w_abs_a, w_abs_b;

    assign o_rdy = !r_vld || i_rdy;
    assign o_vld = r_vld;
    assign o_st  = r_st;

    always_comb begin
        w_abs_a = i_req.a_raw[31] ? 32'(-i_req.a_raw) : i_req.a_raw;
        w_abs_b = i_req.b_raw[31] ? 32'(-i_req.b_raw) : i_req.b_raw;
        n_st         = '0;
        n_st.op      = i_req.op;
        n_st.neg     = i_req.a_raw[31] ^ i_req.b_raw[31];
        n_st.d       = w_abs_b;
        n_st.nq      = {w_abs_a, {FRAC_BITS{1'b0}}};
        n_st.rem     = '0;
        case (t_op'(i_req.op))
            OP_ADD:   n_st.val = 64'(i_req.a_raw) + 64'(i_req.b_raw);
            OP_SUB:   n_st.val = 64'(i_req.a_raw) - 64'(i_req.b_raw);
            OP_MUL:   n_st.val = 64'(i_req.a_raw) * 64'(i_req.b_raw);
            OP_DIV:   n_st.dz  = (i_req.b_raw == 32'sd0);
            OP_LT:    n_st.cmp = i_req.a_raw <  i_req.b_raw;
            OP_GT:    n_st.cmp = i_req.a_raw >  i_req.b_raw;
            OP_LE:    n_st.cmp = i_req.a_raw <= i_req.b_raw;
            OP_GE:    n_st.cmp = i_req.a_raw >= i_req.b_raw;
            OP_EQ:    n_st.cmp = i_req.a_raw == i_req.b_raw;
            OP_NE:    n_st.cmp = i_req.a_raw != i_req.b_raw;
            OP_MIN:   n_st.pre_res = (i_req.a_raw < i_req.b_raw) ? i_req.a_raw
                                                                 : i_req.b_raw;
            OP_MAX:   n_st.pre_res = (i_req.a_raw > i_req.b_raw) ? i_req.a_raw
                                                                 : i_req.b_raw;
            OP_TOINT: n_st.pre_res = i_req.a_raw >>> FRAC_BITS;
            OP_INC:   n_st.pre_res = i_req.a_raw + 32'sd1;
            default:  n_st.val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_st <= n_st;
        end
    end
endmodule
`default_nettype wire

>>> hdl/fpa_div_cell.sv
// One restoring-divider cell: resolves one quotient bit and passes the request on
`timescale 1ns / 1ps
`default_nettype none
module fpa_div_cell import fpa_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_vld,
    input  wire t_div_st i_st,
    output logic         o_rdy,
    output logic         o_vld,
    output t_div_st      o_st,
    input  wire logic    i_rdy
);
    logic    r_vld;
    t_div_st r_st, n_st;
    logic [32:0] w_shift, w_trial;
    logic        w_take;

    assign o_rdy = !r_vld || i_rdy;
    assign o_vld = r_vld;
    assign o_st  = r_st;

    always_comb begin
        // bring down the next numerator bit, try the subtract
        w_shift = {i_st.rem, i_st.nq[NUM_W-1]};
        w_trial = w_shift - {1'b0, i_st.d};
        w_take  = !w_trial[32];
        n_st     = i_st;
        n_st.rem = w_take ? w_trial[31:0] : w_shift[31:0];
        n_st.nq  = {i_st.nq[NUM_W-2:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_st <= n_st;
        end
    end
endmodule
`default_nettype wire

>>> hdl/fpa_back.sv
// Output stage: range checks, truncation, result select and output register
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fpa_back import fpa_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_vld,
    input  wire t_div_st i_st,
    output logic         o_rdy,
    output logic         o_vld,
    output t_out         o_res,
    input  wire logic    i_rdy
);
    logic  r_vld;
    t_out  r_res, n_res;
    logic [63:0]      w_mag, w_sh;
    logic [NUM_W-1:0] w_q;
    logic             w_exact;

    assign o_rdy = !r_vld || i_rdy;
    assign o_vld = r_vld;
    assign o_res = r_res;

    always_comb begin
        w_mag   = i_st.val[63] ? 64'(-i_st.val) : 64'(i_st.val);
        w_sh    = w_mag >> FRAC_BITS;
        w_q     = i_st.nq;
        w_exact = (i_st.rem == 32'd0);
        n_res   = '0;
        case (t_op'(i_st.op))
            OP_ADD, OP_SUB: begin
                if (i_st.val <= ADD_HI && i_st.val >= ADD_LO) begin
                    n_res.result_raw = i_st.val[31:0];
                end else begin
                    n_res.out_of_range = 1'b1;
                end
            end
            OP_MUL: begin
                if (i_st.val <= MUL_HI && i_st.val >= MUL_LO) begin
                    n_res.result_raw = i_st.val[63] ? 32'(-w_sh[31:0]) : w_sh[31:0];
                end else begin
                    n_res.out_of_range = 1'b1;
                end
            end
            OP_DIV: begin
                if (i_st.dz) begin
                    n_res.div_zero = 1'b1;
                end else if (i_st.neg) begin
                    // real quotient must not fall below the lowest value
                    if (w_q < DIV_NEG_HI || (w_q == DIV_NEG_HI && w_exact)) begin
                        n_res.result_raw = 32'(-w_q[31:0]);
                    end else begin
                        n_res.out_of_range = 1'b1;
                    end
                end else begin
                    if (w_q < DIV_POS_HI || (w_q == DIV_POS_HI && w_exact)) begin
                        n_res.result_raw = w_q[31:0];
                    end else begin
                        n_res.out_of_range = 1'b1;
                    end
                end
            end
            OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ, OP_NE: n_res.compare_true = i_st.cmp;
            OP_MIN, OP_MAX, OP_TOINT, OP_INC:          n_res.result_raw = i_st.pre_res;
            default: n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_res <= n_res;
        end
    end

    `FPA_ASSERT(a_flags_excl, !(r_vld && r_res.out_of_range && r_res.div_zero), "both error flags")
    `FPA_ASSERT_IMPL(a_oor_zero, r_vld && r_res.out_of_range, r_res.result_raw == 32'sd0, "oor result not zero")
    `FPA_ASSERT_IMPL(a_dz_zero, r_vld && r_res.div_zero, r_res.result_raw == 32'sd0, "div zero result not zero")
    `FPA_ASSERT_IMPL(a_cmp_zero, r_vld && r_res.compare_true, r_res.result_raw == 32'sd0 && !r_res.out_of_range, "compare with payload")
endmodule
`default_nettype wire

>>> hdl/fixed_point_alu_q24_8.sv
// Top level of the signed Q24.8 fixed-point ALU
// One request enters per cycle unless output back-pressure stalls the chain, and
// each request passes an entry stage, a chain of NUM_W divider cells
// that each resolve one quotient bit, and an output register. Every op takes
// the same path, so results leave in request order. Each stage holds its item
// only while the next one is full, so bubbles close up under output back-pressure.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu_q24_8 import fpa_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);
    logic    w_vld [NUM_W+1];
    logic    w_rdy [NUM_W+1];
    t_div_st w_st  [NUM_W+1];

    fpa_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (i_in_valid),
        .i_req  (i_in_data),
        .o_rdy  (o_in_ready),
        .o_vld  (w_vld[0]),
        .o_st   (w_st[0]),
        .i_rdy  (w_rdy[0])
    );

    for (genvar g = 0; g < NUM_W; g++) begin : g_cell
        fpa_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (w_vld[g]),
            .i_st   (w_st[g]),
            .o_rdy  (w_rdy[g]),
            .o_vld  (w_vld[g+1]),
            .o_st   (w_st[g+1]),
            .i_rdy  (w_rdy[g+1])
        );
    end

    fpa_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (w_vld[NUM_W]),
        .i_st   (w_st[NUM_W]),
        .o_rdy  (w_rdy[NUM_W]),
        .o_vld  (o_out_valid),
        .o_res  (o_out_data),
        .i_rdy  (i_out_ready)
    );
endmodule
`default_nettype wire
